@@ design/ilp_pkg.sv @@
// Shared types, character codes and helpers for the integer literal parser.
`default_nettype none

package ilp_pkg;

    localparam int VALUE_BITS = 128;
    localparam int WORD_BITS  = 64;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_BODY   = 2'd2
    } char_pos_t;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [7:0] CH_UPPER_X  = 8'h58;
    localparam logic [7:0] CH_LOWER_O  = 8'h6f;
    localparam logic [7:0] CH_UPPER_O  = 8'h4f;
    localparam logic [7:0] CH_LOWER_B  = 8'h62;
    localparam logic [7:0] CH_UPPER_B  = 8'h42;
    localparam logic [7:0] SEPARATOR_RESET = 8'h27;
    localparam logic [7:0] TEN         = 8'd10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value_low;
        logic [WORD_BITS-1:0] value_high;
        logic [1:0]           radix_used;
        logic                 invalid;
    } out_item_t;

    // Classification of one character against the current base and separator.
    typedef struct packed {
        logic       is_sep;
        logic       digit_ok;
        logic [3:0] digit;
        logic       prefix_ok;
        radix_t     prefix_radix;
    } char_class_t;

    function automatic logic [4:0] base_of(radix_t r);
        logic [4:0] b;
        unique case (r)
            RADIX_DEC: b = 5'd10;
            RADIX_HEX: b = 5'd16;
            RADIX_OCT: b = 5'd8;
            RADIX_BIN: b = 5'd2;
            default:   b = 5'd10;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ design/ilp_char_decode.sv @@
// Character classifier: digit value, digit validity in the base, prefix letter, separator.
`default_nettype none

module ilp_char_decode
    import ilp_pkg::*;
(
    input  wire logic [7:0]  ch,
    input  wire radix_t      radix,
    input  wire logic [7:0]  separator,
    output char_class_t      cls
);

    logic       hit;
    logic [3:0] dv;

    always_comb begin
        hit = 1'b0;
        dv  = 4'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            hit = 1'b1;
            dv  = 4'(ch - CH_ZERO);
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
            hit = 1'b1;
            dv  = 4'(ch - CH_LOWER_A + TEN);
        end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
            hit = 1'b1;
            dv  = 4'(ch - CH_UPPER_A + TEN);
        end
    end

    always_comb begin
        cls.is_sep   = (ch == separator);
        cls.digit    = dv;
        cls.digit_ok = hit && ({1'b0, dv} < base_of(radix));
        cls.prefix_ok    = 1'b1;
        cls.prefix_radix = RADIX_DEC;
        unique case (ch)
            CH_LOWER_X, CH_UPPER_X: cls.prefix_radix = RADIX_HEX;
            CH_LOWER_O, CH_UPPER_O: cls.prefix_radix = RADIX_OCT;
            CH_LOWER_B, CH_UPPER_B: cls.prefix_radix = RADIX_BIN;
            default:                cls.prefix_ok    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/ilp_parse_state.sv @@
// Literal state: accumulator, base, position and error flag, updated once per character.
`default_nettype none

module ilp_parse_state
    import ilp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire in_item_t   item,
    input  wire logic [7:0] separator,
    output out_item_t       result
);

    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_mac;
    radix_t                radix_reg, radix_next;
    char_pos_t             pos_reg, pos_next;
    logic                  lz_reg, lz_next;
    logic                  err_reg, err_next;
    char_class_t           cls;
    logic [2*WORD_BITS-1:0] value_wide;

    ilp_char_decode u_decode (
        .ch        (item.ch),
        .radix     (radix_reg),
        .separator (separator),
        .cls       (cls)
    );

    // Multiply by a constant base with shifts (two shifted terms summed for decimal), then add the digit.
    always_comb begin
        unique case (radix_reg)
            RADIX_DEC: acc_mac = (acc_reg << 3) + (acc_reg << 1)
                                 + VALUE_BITS'(cls.digit);
            RADIX_HEX: acc_mac = (acc_reg << 4) + VALUE_BITS'(cls.digit);
            RADIX_OCT: acc_mac = (acc_reg << 3) + VALUE_BITS'(cls.digit);
            RADIX_BIN: acc_mac = (acc_reg << 1) + VALUE_BITS'(cls.digit);
            default:   acc_mac = acc_reg;
        endcase
    end

    always_comb begin
        acc_next   = acc_reg;
        radix_next = radix_reg;
        pos_next   = pos_reg;
        lz_next    = lz_reg;
        err_next   = err_reg;
        // prefix letter wins over the separator
        if (pos_reg == POS_SECOND && lz_reg && cls.prefix_ok) begin
            radix_next = cls.prefix_radix;
            pos_next   = POS_BODY;
        end else begin
            if (pos_reg == POS_FIRST) begin
                lz_next = (item.ch == CH_ZERO);
            end
            if (!err_reg && !cls.is_sep) begin
                if (cls.digit_ok) begin
                    acc_next = acc_mac;
                end else begin
                    err_next = 1'b1;
                end
            end
            if (pos_reg == POS_FIRST) begin
                pos_next = POS_SECOND;
            end else begin
                pos_next = POS_BODY;
            end
        end
    end

    always_comb begin
        value_wide        = err_next ? '0 : (2*WORD_BITS)'(acc_next);
        result.value_low  = value_wide[WORD_BITS-1:0];
        result.value_high = value_wide[2*WORD_BITS-1:WORD_BITS];
        result.radix_used = radix_next;
        result.invalid    = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last)) begin
            acc_reg   <= '0;
            radix_reg <= RADIX_DEC;
            pos_reg   <= POS_FIRST;
            lz_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end else if (step) begin
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            pos_reg   <= pos_next;
            lz_reg    <= lz_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

@@ design/integer_literal_parser.sv @@
// Top level: input register, literal state, result register and separator register.
// Result path: a last character waits in the input register, and its result is written
// to the result register and shown on m_data once that register is free.
// Throughput: one character per cycle; only a last character waits, and only while
// the result register is full and not taken. Reset clears the literal state and the
// valid flags and sets the separator to apostrophe.
`default_nettype none

module integer_literal_parser
    import ilp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    in_item_t   in_reg;
    logic       in_valid_reg;
    logic       m_valid_reg;
    out_item_t  out_reg;
    logic [7:0] sep_reg;
    logic       step;
    out_item_t  result;

    // a non-last character needs no room in the result register
    assign step      = in_valid_reg && (!in_reg.last || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    ilp_parse_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_reg),
        .separator (sep_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            sep_reg      <= SEPARATOR_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step && in_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                sep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (step && in_reg.last) begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ design/ilp_checker.sv @@
// Port-level checker for the integer literal parser, bound to the top level.
`default_nettype none

module ilp_checker
    import ilp_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire out_item_t  m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.invalid |-> m_data.value_low == '0 && m_data.value_high == '0)
        else $error("invalid literal with nonzero value");

    // input side only stalls behind a full, untaken result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);

`default_nettype wire
